### rtl/mlcd_pkg.sv
// Shared types, constants and helpers for the memory LCD frame serializer.
// Used by the controller, the datapath and the top level; no dependencies.
package mlcd_pkg;

	localparam int ROWS        = 96;
	localparam int COLUMNS     = 96;
	localparam int LINE_BYTES  = COLUMNS >> 3;
	localparam int STORE_BYTES = ROWS * LINE_BYTES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int CNT_W       = $clog2(LINE_BYTES + 1);

	localparam int BYTE_W    = 8;
	localparam int FUNC_W    = 2;
	localparam int COL_IN_W  = 7;
	localparam int ROW_IN_W  = 7;
	localparam int CBYTE_W   = COL_IN_W - 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] VCOM_MASK = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_RESET = 8'd128;

	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LINE_COMMAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VCOM_ENABLE        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILER_VALUE      = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PIXEL = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_FLUSH = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CLEAR,
		ST_F_CMD,
		ST_F_ADDR,
		ST_F_DATA,
		ST_F_TRAIL,
		ST_F_FINAL
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_CMD,
		EMIT_ADDR,
		EMIT_DATA,
		EMIT_TRAIL,
		EMIT_FINAL
	} emit_t;

	typedef struct packed {
		logic  capture;
		logic  sweep_wr;
		logic  fill_zero;
		logic  pix_rd;
		logic  pix_wr;
		logic  line_start;
		logic  line_next;
		emit_t emit;
		logic  last;
	} ctl_cmd_t;

	typedef struct packed {
		logic row_first;
		logic row_last;
		logic sweep_last;
		logic data_last;
	} dp_status_t;

	localparam logic [3:0] NIBBLE_REV [16] = '{
		4'h0, 4'h8, 4'h4, 4'hC, 4'h2, 4'hA, 4'h6, 4'hE,
		4'h1, 4'h9, 4'h5, 4'hD, 4'h3, 4'hB, 4'h7, 4'hF
	};

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
		return {NIBBLE_REV[v[3:0]], NIBBLE_REV[v[7:4]]};
	endfunction

endpackage

### rtl/mlcd_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependencies.
module mlcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/mlcd_ctl.sv
// Controller state machine of the memory LCD frame serializer.
// Depends on mlcd_pkg; drives the datapath through ctl_cmd_t.
module mlcd_ctl import mlcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  dp_status_t        status,
	output logic              busy,
	output ctl_cmd_t          cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = EMIT_NONE;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_INIT: begin
				// The store is swept to zero once after reset.
				cmd.sweep_wr  = 1'b1;
				cmd.fill_zero = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (func)
						FUNC_PIXEL: state_d = ST_PIX_RD;
						FUNC_CLEAR: state_d = ST_CLEAR;
						FUNC_FLUSH: state_d = ST_F_CMD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_PIX_RD: begin
				cmd.pix_rd = 1'b1;
				state_d    = ST_PIX_WR;
			end
			ST_PIX_WR: begin
				cmd.pix_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_F_CMD: begin
				// Only the first line of a frame carries the command byte.
				if (status.row_first) begin
					cmd.emit = EMIT_CMD;
				end
				state_d = ST_F_ADDR;
			end
			ST_F_ADDR: begin
				cmd.emit       = EMIT_ADDR;
				cmd.line_start = 1'b1;
				state_d        = ST_F_DATA;
			end
			ST_F_DATA: begin
				cmd.emit      = EMIT_DATA;
				cmd.line_next = 1'b1;
				if (status.data_last) begin
					state_d = ST_F_TRAIL;
				end
			end
			ST_F_TRAIL: begin
				cmd.emit = EMIT_TRAIL;
				cmd.last = !status.row_last;
				state_d  = status.row_last ? ST_F_FINAL : ST_IDLE;
			end
			ST_F_FINAL: begin
				cmd.emit = EMIT_FINAL;
				cmd.last = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/mlcd_dp.sv
// Datapath of the memory LCD frame serializer: request capture, frame store,
// configuration registers and the result register. Depends on mlcd_pkg, mlcd_ram.
module mlcd_dp import mlcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_status_t           status,
	input  logic [COL_IN_W-1:0]  col,
	input  logic [ROW_IN_W-1:0]  row,
	input  logic                 pixel_value,
	input  logic [BYTE_W-1:0]    fill_pattern,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output logic                 strobe,
	output logic [BYTE_W-1:0]    spi_byte,
	output logic                 last_of_run,
	output logic                 end_of_frame
);

	logic [BYTE_W-1:0]   cmd_byte_q;
	logic                vcom_q;
	logic [BYTE_W-1:0]   trailer_q;

	logic [ROW_IN_W-1:0] row_q;
	logic [CBYTE_W-1:0]  cbyte_q;
	logic [2:0]          cbit_q;
	logic                pix_ok_q;
	logic                pix_q;
	logic [BYTE_W-1:0]   fill_q;

	logic [ADDR_W-1:0]   sweep_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                strobe_q;
	logic [BYTE_W-1:0]   spi_byte_q;
	logic                last_q;
	logic                eof_q;

	logic [ROW_IN_W-1:0] row_cl;
	logic [COL_IN_W-1:0] col_cl;
	logic [ADDR_W-1:0]   base;
	logic [ADDR_W-1:0]   pix_idx;
	logic [BYTE_W-1:0]   mask;
	logic [ADDR_W-1:0]   ram_addr;
	logic                ram_we;
	logic [BYTE_W-1:0]   ram_wdata;
	logic [BYTE_W-1:0]   ram_rdata;
	logic [BYTE_W-1:0]   emit_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_byte_q <= CMD_RESET;
			vcom_q     <= 1'b1;
			trailer_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WRITE_LINE_COMMAND: cmd_byte_q <= cfg_data;
				REG_VCOM_ENABLE:        vcom_q     <= cfg_data[0];
				REG_TRAILER_VALUE:      trailer_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		row_cl = row;
		if (int'(row) > ROWS - 1) begin
			row_cl = ROW_IN_W'(ROWS - 1);
		end
		col_cl = col;
		if (int'(col) > COLUMNS - 1) begin
			col_cl = COL_IN_W'(COLUMNS - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q    <= row_cl;
			cbyte_q  <= col_cl[COL_IN_W-1:3];
			cbit_q   <= col_cl[2:0];
			pix_ok_q <= (int'(col_cl[COL_IN_W-1:3]) < LINE_BYTES);
			pix_q    <= pixel_value;
			fill_q   <= fill_pattern;
		end
	end

	assign base    = ADDR_W'(row_q) * ADDR_W'(LINE_BYTES);
	assign pix_idx = base + ADDR_W'(cbyte_q);
	assign mask    = 8'h80 >> cbit_q;

	assign status.row_first  = (row_q == '0);
	assign status.row_last   = (row_q == ROW_IN_W'(ROWS - 1));
	assign status.sweep_last = (sweep_q == ADDR_W'(STORE_BYTES - 1));
	assign status.data_last  = (cnt_q == CNT_W'(LINE_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.sweep_wr) begin
				sweep_q <= status.sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (cmd.line_start) begin
				cnt_q <= '0;
			end else if (cmd.line_next) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Line bytes are read in the cycle before the cycle that emits them.
	always_comb begin
		ram_addr  = base;
		ram_we    = 1'b0;
		ram_wdata = ram_rdata | mask;
		if (cmd.sweep_wr) begin
			ram_addr  = sweep_q;
			ram_we    = 1'b1;
			ram_wdata = cmd.fill_zero ? '0 : fill_q;
		end else if (cmd.pix_rd || cmd.pix_wr) begin
			ram_addr  = pix_idx;
			ram_we    = cmd.pix_wr && pix_ok_q;
			ram_wdata = pix_q ? (ram_rdata & ~mask) : (ram_rdata | mask);
		end else if (cmd.line_next && !status.data_last) begin
			ram_addr = base + ADDR_W'(cnt_q) + 1'b1;
		end
	end

	mlcd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (cmd.emit)
			EMIT_CMD:   emit_byte = vcom_q ? (cmd_byte_q ^ VCOM_MASK) : cmd_byte_q;
			EMIT_ADDR:  emit_byte = rev8(BYTE_W'(row_q) + 1'b1);
			EMIT_DATA:  emit_byte = ram_rdata;
			default:    emit_byte = trailer_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q   <= 1'b0;
			spi_byte_q <= '0;
			last_q     <= 1'b0;
			eof_q      <= 1'b0;
		end else begin
			strobe_q   <= (cmd.emit != EMIT_NONE);
			spi_byte_q <= emit_byte;
			last_q     <= cmd.last;
			eof_q      <= (cmd.emit == EMIT_FINAL);
		end
	end

	assign strobe       = strobe_q;
	assign spi_byte     = spi_byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

endmodule

### rtl/memory_lcd_frame_serializer.sv
// Top level of the memory LCD frame serializer: controller plus datapath.
// Depends on mlcd_pkg, mlcd_ctl, mlcd_dp and mlcd_ram.
//
// A request is taken when start is high while busy is low; busy stays high
// until the controller is back in idle. A pixel write keeps busy high
// through a read, then a modify and write of one frame store byte. A clear
// sweeps the frame store one byte a cycle. In a row flush the bytes come out
// one a cycle, each on spi_byte for a single cycle with strobe high, and the
// receiver must take them as they come. The last result shows in the first
// cycle with busy low. After reset a clearing pass zeroes the store with
// busy high; configuration writes are taken at any time.
module memory_lcd_frame_serializer import mlcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [COL_IN_W-1:0]  col,
	input  logic [ROW_IN_W-1:0]  row,
	input  logic                 pixel_value,
	input  logic [BYTE_W-1:0]    fill_pattern,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output logic                 strobe,
	output logic [BYTE_W-1:0]    spi_byte,
	output logic                 last_of_run,
	output logic                 end_of_frame
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	mlcd_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	mlcd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.col          (col),
		.row          (row),
		.pixel_value  (pixel_value),
		.fill_pattern (fill_pattern),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.spi_byte     (spi_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule

### verif/memory_lcd_frame_serializer_tb.sv
// Self-checking testbench for memory_lcd_frame_serializer: directed and random requests,
// with a mirrored frame store that predicts every serial byte of each row flush.
// Depends on mlcd_pkg and the serializer RTL.
`timescale 1ns / 100ps

module memory_lcd_frame_serializer_tb;
	import mlcd_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 24;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              eof;
	} spi_beat_t;

	class frame_store_mirror;
		logic [BYTE_W-1:0] pixels [STORE_BYTES];
		logic [BYTE_W-1:0] line_cmd;
		logic              vcom_on;
		logic [BYTE_W-1:0] trailer;
		spi_beat_t         owed_bytes[$];
		spi_beat_t         row_run[$];
		int                errors;

		function new();
			foreach (pixels[i])
				pixels[i] = '0;
			line_cmd = CMD_RESET;
			vcom_on = 1'b1;
			trailer = '0;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
			case (idx)
				REG_WRITE_LINE_COMMAND: line_cmd = data;
				REG_VCOM_ENABLE:        vcom_on = data[0];
				REG_TRAILER_VALUE:      trailer = data;
				default: ;
			endcase
		endfunction

		function void add_byte(logic [BYTE_W-1:0] data, logic eof);
			spi_beat_t beat;
			beat.data = data;
			beat.last = 1'b0;
			beat.eof = eof;
			row_run.push_back(beat);
		endfunction

		function void take_request(logic [FUNC_W-1:0] op, logic [COL_IN_W-1:0] c,
				logic [ROW_IN_W-1:0] r, logic pv, logic [BYTE_W-1:0] pat);
			int unsigned cc;
			int unsigned rr;
			int unsigned idx;
			logic [BYTE_W-1:0] mask;
			logic [BYTE_W-1:0] line_no;
			logic [BYTE_W-1:0] addr;
			spi_beat_t beat;
			cc = (c > COLUMNS - 1) ? COLUMNS - 1 : c;
			rr = (r > ROWS - 1) ? ROWS - 1 : r;
			case (op)
				FUNC_PIXEL: begin
					if ((cc >> 3) < LINE_BYTES) begin
						idx = rr * LINE_BYTES + (cc >> 3);
						mask = 8'h80 >> (cc % 8);
						// A black pixel (value 0) sets the stored bit.
						if (pv == 1'b0)
							pixels[idx] = pixels[idx] | mask;
						else
							pixels[idx] = pixels[idx] & ~mask;
					end
				end
				FUNC_CLEAR: begin
					foreach (pixels[i])
						pixels[i] = pat;
				end
				FUNC_FLUSH: begin
					row_run.delete();
					if (rr == 0)
						add_byte(vcom_on ? (line_cmd ^ VCOM_MASK) : line_cmd, 1'b0);
					line_no = BYTE_W'(rr + 1);
					for (int i = 0; i < BYTE_W; i++)
						addr[i] = line_no[BYTE_W-1-i];
					add_byte(addr, 1'b0);
					for (int i = 0; i < LINE_BYTES; i++)
						add_byte(pixels[rr * LINE_BYTES + i], 1'b0);
					add_byte(trailer, 1'b0);
					if (rr == ROWS - 1)
						add_byte(trailer, 1'b1);
					beat = row_run.pop_back();
					beat.last = 1'b1;
					row_run.push_back(beat);
					foreach (row_run[i])
						owed_bytes.push_back(row_run[i]);
				end
				default: ;
			endcase
		endfunction

		function void check_byte(logic [BYTE_W-1:0] data, logic last, logic eof);
			spi_beat_t want;
			if (owed_bytes.size() == 0) begin
				$error("unexpected byte: spi_byte %h last_of_run %b end_of_frame %b",
					data, last, eof);
				errors++;
				return;
			end
			want = owed_bytes.pop_front();
			if (data !== want.data) begin
				$error("spi_byte: expected %h, got %h", want.data, data);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %b, got %b", want.last, last);
				errors++;
			end
			if (eof !== want.eof) begin
				$error("end_of_frame: expected %b, got %b", want.eof, eof);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [FUNC_W-1:0] func;
	logic [COL_IN_W-1:0] col;
	logic [ROW_IN_W-1:0] row;
	logic pixel_value;
	logic [BYTE_W-1:0] fill_pattern;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic strobe;
	logic [BYTE_W-1:0] spi_byte;
	logic last_of_run;
	logic end_of_frame;

	frame_store_mirror mirror;
	int unsigned cycle_count = 0;
	bit steady_sender;

	memory_lcd_frame_serializer dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.func,
		.col,
		.row,
		.pixel_value,
		.fill_pattern,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.strobe,
		.spi_byte,
		.last_of_run,
		.end_of_frame
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			mirror.check_byte(spi_byte, last_of_run, end_of_frame);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("memory_lcd_frame_serializer_tb failed");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge that accepted the request with start
	// still high, so the caller decides in that same step whether it stays high.
	task automatic issue(input logic [FUNC_W-1:0] op, input logic [COL_IN_W-1:0] c,
			input logic [ROW_IN_W-1:0] r, input logic pv, input logic [BYTE_W-1:0] pat);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= op;
		col <= c;
		row <= r;
		pixel_value <= pv;
		fill_pattern <= pat;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		mirror.take_request(op, c, r, pv, pat);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (busy || mirror.owed_bytes.size() != 0);
		// The last byte shows in the first cycle in which busy is low.
		repeat (2) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		mirror.write_register(idx, data);
	endtask

	task automatic set_registers(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] vcom,
			input logic [BYTE_W-1:0] trail);
		write_cfg(REG_WRITE_LINE_COMMAND, cmd);
		write_cfg(REG_VCOM_ENABLE, vcom);
		write_cfg(REG_TRAILER_VALUE, trail);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_request(output int used);
		int pick;
		int first_row;
		int run_len;
		logic [ROW_IN_W-1:0] r;
		pick = $urandom_range(0, 99);
		used = 1;
		r = ($urandom_range(0, 9) < 7) ? ROW_IN_W'($urandom_range(0, ROWS - 1))
			: ROW_IN_W'($urandom_range(0, 127));
		if (pick < 40) begin
			issue(FUNC_PIXEL, COL_IN_W'($urandom_range(0, 127)), r, 1'($urandom_range(0, 1)),
				BYTE_W'($urandom));
		end else if (pick < 44) begin
			issue(FUNC_CLEAR, COL_IN_W'($urandom), ROW_IN_W'($urandom), 1'($urandom),
				BYTE_W'($urandom_range(0, 255)));
		end else if (pick < 48) begin
			issue(FUNC_UNUSED, COL_IN_W'($urandom), ROW_IN_W'($urandom), 1'($urandom),
				BYTE_W'($urandom));
		end else if (pick < 62) begin
			// A run of consecutive row flushes, the way a frame goes out, often up to the end.
			run_len = $urandom_range(3, 12);
			first_row = $urandom_range(0, 1) ? ROWS - run_len
				: $urandom_range(0, ROWS - run_len);
			for (int i = 0; i < run_len; i++)
				issue(FUNC_FLUSH, COL_IN_W'($urandom), ROW_IN_W'(first_row + i), 1'($urandom),
					BYTE_W'($urandom));
			used = run_len;
		end else begin
			case ($urandom_range(0, 3))
				0: r = '0;
				1: r = ROW_IN_W'(ROWS - 1);
				default: ;
			endcase
			issue(FUNC_FLUSH, COL_IN_W'($urandom), r, 1'($urandom), BYTE_W'($urandom));
		end
	endtask

	initial begin
		int count;
		int used;
		mirror = new();
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_PIXEL;
		col = '0;
		row = '0;
		pixel_value = 1'b0;
		fill_pattern = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WRITE_LINE_COMMAND;
		cfg_data = '0;
		steady_sender = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Wait out the clearing pass that follows reset.
		drain();

		// Directed requests with the reset register values.
		issue(FUNC_FLUSH, 7'd0, 7'd0, 1'b0, 8'h00);
		issue(FUNC_PIXEL, 7'd0, 7'd0, 1'b0, 8'h00);
		issue(FUNC_PIXEL, 7'd127, 7'd127, 1'b0, 8'hFF);
		issue(FUNC_PIXEL, 7'd7, 7'd0, 1'b0, 8'h00);
		issue(FUNC_PIXEL, 7'd8, 7'd0, 1'b0, 8'h00);
		issue(FUNC_FLUSH, 7'd0, 7'd0, 1'b0, 8'h00);
		issue(FUNC_FLUSH, 7'd0, 7'd127, 1'b0, 8'h00);
		issue(FUNC_PIXEL, 7'd0, 7'd0, 1'b1, 8'h00);
		issue(FUNC_FLUSH, 7'd127, 7'd0, 1'b1, 8'hFF);
		issue(FUNC_UNUSED, 7'd127, 7'd127, 1'b1, 8'hFF);
		issue(FUNC_CLEAR, 7'd0, 7'd0, 1'b0, 8'hFF);
		issue(FUNC_PIXEL, 7'd127, 7'd127, 1'b1, 8'h00);
		issue(FUNC_PIXEL, 7'd5, 7'd95, 1'b1, 8'h00);
		issue(FUNC_FLUSH, 7'd0, 7'd95, 1'b0, 8'h00);
		issue(FUNC_FLUSH, 7'd0, 7'd94, 1'b0, 8'h00);
		issue(FUNC_CLEAR, 7'd0, 7'd0, 1'b0, 8'hA5);
		issue(FUNC_FLUSH, 7'd0, 7'd48, 1'b0, 8'h00);
		issue(FUNC_CLEAR, 7'd0, 7'd0, 1'b0, 8'h5A);
		issue(FUNC_FLUSH, 7'd0, 7'd127, 1'b0, 8'h00);
		issue(FUNC_CLEAR, 7'd0, 7'd0, 1'b0, 8'h00);
		issue(FUNC_FLUSH, 7'd0, 7'd0, 1'b0, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: set_registers(8'h00, 8'h00, 8'hFF);
				1: set_registers(8'hFF, 8'hFF, 8'h00);
				default: set_registers(BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
			endcase
			steady_sender = ($urandom_range(0, 3) == 0);
			issue(FUNC_FLUSH, 7'd0, 7'd0, 1'b0, 8'h00);
			count = 1;
			while (count < PHASE_REQUESTS) begin
				random_request(used);
				count += used;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mirror.errors == 0)
			$display("memory_lcd_frame_serializer_tb passed");
		else
			$display("memory_lcd_frame_serializer_tb failed");
		$finish;
	end

endmodule
